// ===== rtl/ssd_pkg.sv =====
package ssd_pkg;

    localparam int FRAME_BITS = 16;
    localparam int BYTE_BITS  = 8;
    localparam int CNT_W      = $clog2(FRAME_BITS);

    typedef struct packed {
        logic [BYTE_BITS-1:0] sel;
        logic [BYTE_BITS-1:0] seg;
    } frame_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_EMIT
    } fe_state_t;

endpackage

// ===== rtl/ssd_ifs.sv =====
interface ssd_tick_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] display_value;

    modport source (output valid, output display_value, input ready);
    modport sink   (input valid, input display_value, output ready);
endinterface

interface ssd_bit_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic latch_after;
    logic last_bit;

    modport source (output valid, output serial_bit, output latch_after, output last_bit,
                    input ready);
    modport sink   (input valid, input serial_bit, input latch_after, input last_bit,
                    output ready);
endinterface

// ===== rtl/ssd_front.sv =====
module ssd_front #(
    parameter int NUM_DIGITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    ssd_tick_if.sink          tick,
    output logic              push,
    output ssd_pkg::frame_t   push_frame,
    input  logic              q_full
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    function automatic int unsigned pow10(input int n);
        int unsigned p;
        p = 1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam int unsigned MAX_VAL = pow10(NUM_DIGITS) - 1;

    function automatic logic [7:0] seg_lut(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hC0;
        endcase
        return s;
    endfunction

    ssd_pkg::fe_state_t state_reg, state_next;
    logic [15:0]        period_reg;
    logic [15:0]        count_reg, count_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [3:0]         digit_reg [NUM_DIGITS];
    logic [3:0]         digit_next [NUM_DIGITS];
    logic [15:0]        val_reg, val_next;

    logic [15:0]        clamped;
    logic [31:0]        prod;
    logic [15:0]        quot;
    logic [15:0]        rem;
    logic [IDX_W-1:0]   conv_idx;
    logic [IDX_W-1:0]   scan_inc;
    logic               accept;

    always_comb
    begin
        if (tick.display_value[15])
        begin
            clamped = '0;
        end
        else if ({16'd0, tick.display_value} > MAX_VAL)
        begin
            clamped = MAX_VAL[15:0];
        end
        else
        begin
            clamped = tick.display_value;
        end
    end

    // Divide by ten through the reciprocal; exact for every 16-bit value.
    assign prod     = val_reg * 32'd52429;
    assign quot     = 16'(prod >> 19);
    assign rem      = val_reg - ((quot << 3) + (quot << 1));
    assign conv_idx = IDX_W'(NUM_DIGITS - 1) - step_reg;
    assign scan_inc = (scan_reg == IDX_W'(NUM_DIGITS - 1)) ? '0 : scan_reg + 1'b1;

    assign tick.ready = (state_reg == ssd_pkg::FE_IDLE) && !q_full;
    assign accept     = tick.valid && tick.ready;

    assign push_frame.sel = 8'b1 << scan_reg;
    assign push_frame.seg = seg_lut(digit_reg[scan_reg]);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        step_next  = step_reg;
        val_next   = val_reg;
        digit_next = digit_reg;
        push       = 1'b0;
        unique case (state_reg)
            ssd_pkg::FE_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg == period_reg)
                    begin
                        count_next = 16'd1;
                        val_next   = clamped;
                        step_next  = '0;
                        state_next = ssd_pkg::FE_CONV;
                    end
                    else
                    begin
                        count_next = count_reg + 16'd1;
                        push       = 1'b1;
                        scan_next  = scan_inc;
                    end
                end
            end
            ssd_pkg::FE_CONV:
            begin
                digit_next[conv_idx] = rem[3:0];
                val_next             = quot;
                step_next            = step_reg + 1'b1;
                if (step_reg == IDX_W'(NUM_DIGITS - 1))
                begin
                    state_next = ssd_pkg::FE_EMIT;
                end
            end
            ssd_pkg::FE_EMIT:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    scan_next  = scan_inc;
                    state_next = ssd_pkg::FE_IDLE;
                end
            end
            default:
            begin
                state_next = ssd_pkg::FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ssd_pkg::FE_IDLE;
            period_reg <= 16'd200;
            count_reg  <= '0;
            scan_reg   <= '0;
            step_reg   <= '0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            step_reg  <= step_next;
            digit_reg <= digit_next;
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== rtl/ssd_queue.sv =====
module ssd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ssd_pkg::frame_t push_frame,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ssd_pkg::frame_t pop_frame,
    output logic [1:0]      count
);

    ssd_pkg::frame_t entry_reg [2];
    logic            wr_reg, wr_next;
    logic            rd_reg, rd_next;
    logic [1:0]      count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign pop_frame = entry_reg[rd_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_next    = push ? !wr_reg : wr_reg;
        rd_next    = pop ? !rd_reg : rd_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_frame;
        end
    end

endmodule

// ===== rtl/ssd_serializer.sv =====
module ssd_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  ssd_pkg::frame_t q_frame,
    output logic            pop,
    ssd_bit_if.source       bits
);

    logic                                   busy_reg, busy_next;
    logic [ssd_pkg::CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ssd_pkg::FRAME_BITS-1:0]         shift_reg, shift_next;
    logic                                   beat;
    logic                                   frame_done;

    assign beat       = bits.valid && bits.ready;
    assign frame_done = beat && (cnt_reg == ssd_pkg::CNT_W'(ssd_pkg::FRAME_BITS - 1));
    assign pop        = !q_empty && (!busy_reg || frame_done);

    assign bits.valid       = busy_reg;
    assign bits.serial_bit  = shift_reg[ssd_pkg::FRAME_BITS-1];
    assign bits.latch_after = (cnt_reg[2:0] == 3'(ssd_pkg::BYTE_BITS - 1));
    assign bits.last_bit    = (cnt_reg == ssd_pkg::CNT_W'(ssd_pkg::FRAME_BITS - 1));

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = q_frame;
        end
        else if (frame_done)
        begin
            busy_next = 1'b0;
        end
        else if (beat)
        begin
            cnt_next   = cnt_reg + 1'b1;
            shift_next = shift_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

// ===== rtl/four_digit_seven_segment_scan_driver.sv =====
// Scan driver for a multiplexed seven-segment display behind a shift-register chain.
// The tick channel takes one beat per scan tick, carrying the signed value to show.
// The bits channel gives sixteen beats per tick, most significant bit first: the
// one-hot digit select byte, then the active-low segment byte of that digit.
// Each beat flags whether a latch pulse follows it and whether it ends the frame.
// The refresh period is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. A tick that
// finds the tick counter equal to the period reloads the digits: the value is clamped
// to the display range and split one decimal digit per cycle, then its frame is pushed
// once the queue has room; other ticks push their frame in the cycle they are accepted.
// The serializer pops a frame into its shift register to send it, and pops the next one
// in the same cycle as the last bit, so frames follow back to back. A two-entry frame
// queue lets the front accept ticks while the serializer drains. When the receiver
// stalls, the current bit holds and the queue fills up, then ready on the tick channel
// falls until room is made. Reset clears the scan index, the tick counter and the
// digits (showing all zeros) and sets the refresh period to 200.
module four_digit_seven_segment_scan_driver #(
    parameter int NUM_DIGITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    ssd_tick_if.sink    tick,
    ssd_bit_if.source   bits
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    logic [1:0]      q_count;
    ssd_pkg::frame_t push_frame;
    ssd_pkg::frame_t pop_frame;

    ssd_front #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .tick       (tick),
        .push       (push),
        .push_frame (push_frame),
        .q_full     (q_full)
    );

    ssd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .pop_frame  (pop_frame),
        .count      (q_count)
    );

    ssd_serializer u_ser (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_frame (pop_frame),
        .pop     (pop),
        .bits    (bits)
    );

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count != 2'd3)
        else $error("frame queue count out of range");

    a_last_latches: assert property (@(posedge clk) disable iff (!rst_n)
        bits.valid && bits.last_bit |-> bits.latch_after)
        else $error("frame end without latch pulse");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        bits.valid && bits.ready && !bits.last_bit |=> bits.valid)
        else $error("frame broken off before its last bit");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push || pop)
        else $error("push into full frame queue");
`endif

endmodule

// ===== test/ssd_frame_checker.sv =====
module ssd_frame_checker #(
    parameter int NUM_DIGITS = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [15:0] cfg_wdata,
    ssd_tick_if tick,
    ssd_bit_if bits,
    output int fail_count,
    output int pending,
    output int ticks_seen,
    output int beats_checked,
    output int reloads_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic serial_bit;
        logic latch_after;
        logic last_bit;
    } bit_beat_t;

    localparam logic [7:0] SEG_CODE [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    bit_beat_t   expected_bits[$];
    logic [15:0] refresh_period;
    logic [15:0] tick_count;
    int          scan_index;
    logic [3:0]  shown_digits[NUM_DIGITS];

    task automatic clamp_and_split(input logic signed [15:0] value);
        int remaining;
        int max_value;
        max_value = 1;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            max_value = max_value * 10;
        end
        max_value = max_value - 1;
        remaining = value;
        if (remaining < 0)
        begin
            remaining = 0;
        end
        if (remaining > max_value)
        begin
            remaining = max_value;
        end
        for (int i = NUM_DIGITS - 1; i >= 0; i--)
        begin
            shown_digits[i] = 4'(remaining % 10);
            remaining = remaining / 10;
        end
    endtask

    task automatic queue_frame(input logic signed [15:0] value);
        ssd_pkg::frame_t frame;
        bit_beat_t       beat;
        if (tick_count == refresh_period)
        begin
            tick_count = '0;
            clamp_and_split(value);
            reloads_seen++;
        end
        frame.sel             = '0;
        frame.sel[scan_index] = 1'b1;
        frame.seg             = SEG_CODE[shown_digits[scan_index]];
        for (int k = 0; k < ssd_pkg::FRAME_BITS; k++)
        begin
            beat.serial_bit  = frame[ssd_pkg::FRAME_BITS - 1 - k];
            beat.latch_after = ((k % ssd_pkg::BYTE_BITS) == ssd_pkg::BYTE_BITS - 1);
            beat.last_bit    = (k == ssd_pkg::FRAME_BITS - 1);
            expected_bits.push_back(beat);
        end
        scan_index = (scan_index + 1) % NUM_DIGITS;
        tick_count = tick_count + 16'd1;
    endtask

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    task automatic check_beat();
        bit_beat_t want;
        if (expected_bits.size() == 0)
        begin
            note_mismatch($sformatf("bit beat with nothing expected (bit %0b latch %0b last %0b)",
                                    bits.serial_bit, bits.latch_after, bits.last_bit));
        end
        else
        begin
            want = expected_bits.pop_front();
            beats_checked++;
            if (bits.serial_bit !== want.serial_bit || bits.latch_after !== want.latch_after ||
                bits.last_bit !== want.last_bit)
            begin
                note_mismatch($sformatf(
                    "beat %0d expected bit %0b latch %0b last %0b, got bit %0b latch %0b last %0b",
                    beats_checked, want.serial_bit, want.latch_after, want.last_bit,
                    bits.serial_bit, bits.latch_after, bits.last_bit));
            end
        end
    endtask

    initial
    begin
        fail_count    = 0;
        ticks_seen    = 0;
        beats_checked = 0;
        reloads_seen  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_period = 16'd200;
            tick_count     = '0;
            scan_index     = 0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                shown_digits[i] = '0;
            end
            expected_bits.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                refresh_period = cfg_wdata;
            end
            if (bits.valid && bits.ready)
            begin
                check_beat();
            end
            if (tick.valid && tick.ready)
            begin
                ticks_seen++;
                queue_frame(tick.display_value);
            end
        end
        pending = expected_bits.size();
    end

endmodule

// ===== test/four_digit_seven_segment_scan_driver_tb.sv =====
module four_digit_seven_segment_scan_driver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [15:0] DIRECTED_VALUES [6] = '{
        16'sh8000, 16'sd32767, 16'sd1234, 16'sd5678, 16'sd9999, 16'sd10000
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int fail_count;
    int pending;
    int ticks_seen;
    int beats_checked;
    int reloads_seen;

    int idle_pct;
    int stall_pct;
    int hold_left;
    int cycles;

    ssd_tick_if tick_ch ();
    ssd_bit_if  bit_ch ();

    four_digit_seven_segment_scan_driver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tick      (tick_ch),
        .bits      (bit_ch)
    );

    ssd_frame_checker scan_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .tick          (tick_ch),
        .bits          (bit_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .ticks_seen    (ticks_seen),
        .beats_checked (beats_checked),
        .reloads_seen  (reloads_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("four_digit_seven_segment_scan_driver verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                bit_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                bit_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic signed [15:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            return 16'($urandom_range(9999));
        end
        if (roll < 85)
        begin
            return 16'($urandom);
        end
        case ($urandom_range(7))
            0: return 16'sd9998;
            1: return 16'sd9999;
            2: return 16'sd10000;
            3: return 16'sd10001;
            4: return -16'sd1;
            5: return 16'sd0;
            6: return 16'sh8000;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic send_tick(input logic signed [15:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            tick_ch.valid = 1'b0;
            @(negedge clk);
        end
        tick_ch.valid         = 1'b1;
        tick_ch.display_value = value;
        @(posedge clk);
        while (!tick_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_period(input logic [15:0] period);
        wait (pending == 0);
        repeat (20) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = period;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] period, input int count, input int idle,
                             input int stall, input int hold);
        write_period(period);
        idle_pct  = idle;
        stall_pct = stall;
        hold_left = hold;
        for (int i = 0; i < count; i++)
        begin
            send_tick(pick_value());
        end
        tick_ch.valid = 1'b0;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.display_value = '0;
        bit_ch.ready          = 1'b0;
        idle_pct              = 0;
        stall_pct             = 0;
        hold_left             = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // With a period of zero the very first tick after reset reloads the digits.
        write_period(16'd0);
        send_tick(16'sd4321);
        tick_ch.valid = 1'b0;

        write_period(16'd4);
        for (int i = 0; i < 24; i++)
        begin
            send_tick(DIRECTED_VALUES[i / 4]);
        end
        tick_ch.valid = 1'b0;

        run_phase(16'd1, 15, 0, 0, 0);
        run_phase(16'd2, 15, 87, 0, 0);
        run_phase(16'd3, 15, 0, 87, 0);
        run_phase(16'd5, 15, 7, 7, 0);
        run_phase(16'd65535, 16, 0, 0, 300);
        // The count is now far above one, so this period holds the digits until a wrap.
        run_phase(16'd1, 8, 7, 7, 0);

        wait (pending == 0);
        repeat (40) @(posedge clk);

        $display("Ticks sent: %0d, bit beats checked: %0d, digit reloads: %0d.",
                 ticks_seen, beats_checked, reloads_seen);
        $display("Periods 0 through 65535, clamped and negative values, and a long output stall.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("four_digit_seven_segment_scan_driver verification clean");
        end
        else
        begin
            $display("four_digit_seven_segment_scan_driver verification failed");
        end
        $finish;
    end

endmodule
